// ===== rtl/ksin_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksin_pkg
// Shared constants, types and tables of the key-tuned sine oscillator.
// ----------------------------------------------------------------------------
package ksin_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS    = 16;

  localparam int QTAB_SIZE  = 1 << SINE_ADDR_BITS;
  localparam int ANGLE_DIV  = 4 * QTAB_SIZE;
  localparam int NUM_KEYS   = 13;
  localparam int KEY_IDX_W  = $clog2(NUM_KEYS);
  localparam int KEY_W      = 8;
  localparam int NOTE_W     = 7;
  localparam int FREQ_W     = 26;
  localparam int SCALE_W    = 36;
  localparam int SCALE_LO_W = 18;
  localparam int SCALE_HI_W = SCALE_W - SCALE_LO_W;
  localparam int PROD_W     = FREQ_W + SCALE_W;
  localparam int STEP_SHIFT = 64 - PHASE_BITS;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 36'd5864062015;
  localparam logic [NOTE_W-1:0]  NOTE_RESET  = NOTE_W'("c");

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam longint      ONE_Q30 = longint'(1) << 30;
  localparam longint      PEAK    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;

  // request kinds
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_KEY  = 1'b1;

  typedef logic [SAMPLE_BITS-2:0] qtab_t [QTAB_SIZE];

  typedef struct packed {
    logic                  hit;
    logic [KEY_IDX_W-1:0]  idx;
    logic [NOTE_W-1:0]     letter;
  } key_map_t;

  // status of the step table toward the top level
  typedef struct packed {
    logic                  busy;       // recompute sweep running
    logic                  seed;       // reset sweep writes the first entry
    logic [PHASE_BITS-1:0] seed_step;
  } sweep_stat_t;

  function automatic key_map_t key_lookup(input logic [KEY_W-1:0] code);
    key_map_t m;
    m.hit = 1'b1;
    case (code)
      KEY_W'("z"): begin m.idx = KEY_IDX_W'(0);  m.letter = NOTE_W'("c"); end
      KEY_W'("s"): begin m.idx = KEY_IDX_W'(1);  m.letter = NOTE_W'("C"); end
      KEY_W'("x"): begin m.idx = KEY_IDX_W'(2);  m.letter = NOTE_W'("d"); end
      KEY_W'("d"): begin m.idx = KEY_IDX_W'(3);  m.letter = NOTE_W'("D"); end
      KEY_W'("c"): begin m.idx = KEY_IDX_W'(4);  m.letter = NOTE_W'("e"); end
      KEY_W'("v"): begin m.idx = KEY_IDX_W'(5);  m.letter = NOTE_W'("f"); end
      KEY_W'("g"): begin m.idx = KEY_IDX_W'(6);  m.letter = NOTE_W'("F"); end
      KEY_W'("b"): begin m.idx = KEY_IDX_W'(7);  m.letter = NOTE_W'("g"); end
      KEY_W'("h"): begin m.idx = KEY_IDX_W'(8);  m.letter = NOTE_W'("G"); end
      KEY_W'("n"): begin m.idx = KEY_IDX_W'(9);  m.letter = NOTE_W'("a"); end
      KEY_W'("j"): begin m.idx = KEY_IDX_W'(10); m.letter = NOTE_W'("A"); end
      KEY_W'("m"): begin m.idx = KEY_IDX_W'(11); m.letter = NOTE_W'("b"); end
      KEY_W'(","): begin m.idx = KEY_IDX_W'(12); m.letter = NOTE_W'("c"); end
      default: begin
        m.hit    = 1'b0;
        m.idx    = '0;
        m.letter = '0;
      end
    endcase
    return m;
  endfunction

  // note frequencies, Q16 hertz, C4 up to C5
  function automatic logic [FREQ_W-1:0] key_freq(input logic [KEY_IDX_W-1:0] idx);
    logic [FREQ_W-1:0] f;
    case (idx)
      KEY_IDX_W'(0):  f = FREQ_W'(17145922);
      KEY_IDX_W'(1):  f = FREQ_W'(18165465);
      KEY_IDX_W'(2):  f = FREQ_W'(19245629);
      KEY_IDX_W'(3):  f = FREQ_W'(20390019);
      KEY_IDX_W'(4):  f = FREQ_W'(21602501);
      KEY_IDX_W'(5):  f = FREQ_W'(22887006);
      KEY_IDX_W'(6):  f = FREQ_W'(24247927);
      KEY_IDX_W'(7):  f = FREQ_W'(25689784);
      KEY_IDX_W'(8):  f = FREQ_W'(27217428);
      KEY_IDX_W'(9):  f = FREQ_W'(28835840);
      KEY_IDX_W'(10): f = FREQ_W'(30550524);
      KEY_IDX_W'(11): f = FREQ_W'(32367116);
      KEY_IDX_W'(12): f = FREQ_W'(34291778);
      default:        f = '0;
    endcase
    return f;
  endfunction

  // Quarter-wave sine, evaluated at elaboration. Entry i is the sine at
  // (2i+1)*pi/(4N): Q30 Taylor series up to x^13, clamped, scaled to PEAK.
  function automatic qtab_t build_qtab();
    qtab_t       q;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    longint      s;
    for (int i = 0; i < QTAB_SIZE; i++) begin
      x  = (64'(2 * i + 1) * PI_Q30) / ANGLE_DIV;
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      t  = ((t * x2) >> 30) / 6;   s = s - longint'(t);
      t  = ((t * x2) >> 30) / 20;  s = s + longint'(t);
      t  = ((t * x2) >> 30) / 42;  s = s - longint'(t);
      t  = ((t * x2) >> 30) / 72;  s = s + longint'(t);
      t  = ((t * x2) >> 30) / 110; s = s - longint'(t);
      t  = ((t * x2) >> 30) / 156; s = s + longint'(t);
      if (s < 0) s = 0;
      if (s > ONE_Q30) s = ONE_Q30;
      q[i] = (SAMPLE_BITS - 1)'((s * PEAK + (ONE_Q30 >> 1)) >> 30);
    end
    return q;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ksin_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksin_if
// Valid/ready channels of the oscillator: requests, samples, tuning writes.
// ----------------------------------------------------------------------------
interface ksin_cmd_if;
  import ksin_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [KEY_W-1:0] key_code;
  modport source (output valid, action, key_code, input ready);
  modport sink   (input valid, action, key_code, output ready);
endinterface

interface ksin_smp_if;
  import ksin_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [NOTE_W-1:0]             note_letter;
  modport source (output valid, sample, note_letter, input ready);
  modport sink   (input valid, sample, note_letter, output ready);
endinterface

interface ksin_cfg_if;
  import ksin_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCALE_W-1:0] tuning_scale;
  modport source (output valid, tuning_scale, input ready);
  modport sink   (input valid, tuning_scale, output ready);
endinterface
`default_nettype wire

// ===== rtl/ksin_sine_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksin_sine_rom
// Quarter-wave sine ROM, one registered read port.
// ----------------------------------------------------------------------------
module ksin_sine_rom (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic [ksin_pkg::SINE_ADDR_BITS-1:0] addr,
  output logic      [ksin_pkg::SAMPLE_BITS-2:0]    dout
);
  import ksin_pkg::*;

  localparam qtab_t QTAB = build_qtab();

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= QTAB[addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ksin_step_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ksin_step_table
// Phase step per key, held in a small memory. A sweep recomputes all entries
// after reset and after each tuning write; keys read it through a register.
// ----------------------------------------------------------------------------
module ksin_step_table (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ksin_pkg::SCALE_W-1:0]    cfg_data,
  input  wire logic                            rd_en,
  input  wire logic [ksin_pkg::KEY_IDX_W-1:0]  rd_idx,
  output logic      [ksin_pkg::PHASE_BITS-1:0] rd_step,
  output ksin_pkg::sweep_stat_t                stat
);
  import ksin_pkg::*;

  logic [PHASE_BITS-1:0] mem [NUM_KEYS];

  logic [SCALE_W-1:0]           scale;
  logic                         sweep_on;
  logic                         init;
  logic [KEY_IDX_W-1:0]         cnt;
  logic                         s1_valid;
  logic [KEY_IDX_W-1:0]         s1_idx;
  logic [FREQ_W+SCALE_LO_W-1:0] p_lo;
  logic [FREQ_W+SCALE_HI_W-1:0] p_hi;
  logic [FREQ_W-1:0]            freq;
  logic [PROD_W-1:0]            prod;
  logic [PHASE_BITS-1:0]        wstep;

  assign freq  = key_freq(cnt);
  assign prod  = PROD_W'({p_hi, SCALE_LO_W'(0)}) + PROD_W'(p_lo);
  assign wstep = PHASE_BITS'(prod >> STEP_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      scale    <= SCALE_RESET;
      sweep_on <= 1'b1;
      init     <= 1'b1;
      cnt      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= sweep_on;
      if (cfg_we) begin
        scale    <= cfg_data;
        sweep_on <= 1'b1;
        cnt      <= '0;
      end else if (sweep_on) begin
        if (cnt == KEY_IDX_W'(NUM_KEYS - 1)) begin
          sweep_on <= 1'b0;
        end else begin
          cnt <= cnt + KEY_IDX_W'(1);
        end
      end
      if (s1_valid && s1_idx == KEY_IDX_W'(NUM_KEYS - 1)) begin
        init <= 1'b0;
      end
    end
  end

  // 26x36 product split in two 26x18 halves, summed in the next stage
  always_ff @(posedge clk) begin
    s1_idx <= cnt;
    p_lo   <= freq * scale[SCALE_LO_W-1:0];
    p_hi   <= freq * scale[SCALE_W-1:SCALE_LO_W];
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      mem[s1_idx] <= wstep;
    end
    if (rd_en) begin
      rd_step <= mem[rd_idx];
    end
  end

  assign stat.busy      = sweep_on || s1_valid;
  assign stat.seed      = s1_valid && init && (s1_idx == '0);
  assign stat.seed_step = wstep;

endmodule
`default_nettype wire

// ===== rtl/key_tuned_sine_oscillator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_tuned_sine_oscillator
// Keyboard-tuned DDS sine oscillator with Q15 output.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - requests: action 0 is a sample tick, action 1 a key press carrying
//          key_code. One request per cycle is taken while ready, ticks and keys mixed.
//   smp  - one sample and the current note letter per sample tick, in order.
//          Key presses give no result.
//   cfg  - tuning_scale write (2^48 / sample rate). Affects later key presses.
// Path: a tick's sample is registered first at the sine ROM read, then in the
//   output register. A key press retunes the very next tick; its step comes
//   from the step table's read register in the next cycle and is forwarded.
// Throughput: one request per cycle while no sweep runs and smp does not stall,
//   set by the phase adder feedback and the single ROM read port.
// Reset and tuning writes start a sweep that recomputes the 13 key steps;
//   cmd.ready and cfg.ready stay low meanwhile.
// When smp is stalled, one more tick fits in the ROM stage; after that
//   cmd.ready drops until the output register drains.
// ----------------------------------------------------------------------------
module key_tuned_sine_oscillator (
  input  wire logic   clk,
  input  wire logic   rst,
  ksin_cmd_if.sink    cmd,
  ksin_smp_if.source  smp,
  ksin_cfg_if.sink    cfg
);
  import ksin_pkg::*;

  sweep_stat_t stat;

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_step;
  logic [NOTE_W-1:0]     current_note;

  logic                  kp_valid;
  logic [NOTE_W-1:0]     kp_letter;
  logic [PHASE_BITS-1:0] rd_step;

  logic                      s1_valid;
  logic                      s1_neg;
  logic [NOTE_W-1:0]         s1_note;
  logic [SAMPLE_BITS-2:0]    rom_dout;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic [NOTE_W-1:0]             out_note;

  logic                          adv_out;
  logic                          s1_free;
  logic                          cmd_acc;
  logic                          tick_acc;
  logic                          key_acc;
  logic                          cfg_we;
  key_map_t                      kmap;
  logic [PHASE_BITS-1:0]         eff_step;
  logic [NOTE_W-1:0]             eff_note;
  logic [1:0]                    quad;
  logic [SINE_ADDR_BITS-1:0]     idx;
  logic [SINE_ADDR_BITS-1:0]     rom_addr;
  logic signed [SAMPLE_BITS-1:0] mag;
  logic signed [SAMPLE_BITS-1:0] sample_val;

  assign adv_out   = !out_valid || smp.ready;
  assign s1_free   = !s1_valid || adv_out;
  assign cmd.ready = !stat.busy && s1_free;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign tick_acc  = cmd_acc && (cmd.action == ACT_TICK);
  assign key_acc   = cmd_acc && (cmd.action == ACT_KEY);
  assign kmap      = key_lookup(cmd.key_code);

  assign cfg.ready = !stat.busy;
  assign cfg_we    = cfg.valid && cfg.ready;

  // forward a key press from the previous cycle to this cycle's tick
  assign eff_step = kp_valid ? rd_step : phase_step;
  assign eff_note = kp_valid ? kp_letter : current_note;

  assign quad     = phase[PHASE_BITS-1 -: 2];
  assign idx      = phase[PHASE_BITS-3 -: SINE_ADDR_BITS];
  assign rom_addr = quad[0] ? ~idx : idx;

  ksin_step_table u_step (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg.tuning_scale),
    .rd_en    (key_acc && kmap.hit),
    .rd_idx   (kmap.idx),
    .rd_step  (rd_step),
    .stat     (stat)
  );

  ksin_sine_rom u_rom (
    .clk  (clk),
    .en   (tick_acc),
    .addr (rom_addr),
    .dout (rom_dout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      current_note <= NOTE_RESET;
      kp_valid     <= 1'b0;
    end else begin
      kp_valid <= key_acc && kmap.hit;
      if (kp_valid) begin
        current_note <= kp_letter;
      end
      if (tick_acc) begin
        phase <= phase + eff_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    kp_letter <= kmap.letter;
    if (stat.seed) begin
      phase_step <= stat.seed_step;
    end else if (kp_valid) begin
      phase_step <= rd_step;
    end
  end

  // ROM stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= tick_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_neg  <= quad[1];
      s1_note <= eff_note;
    end
  end

  assign mag        = {1'b0, rom_dout};
  assign sample_val = s1_neg ? -mag : mag;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      out_sample <= sample_val;
      out_note   <= s1_note;
    end
  end

  assign smp.valid       = out_valid;
  assign smp.sample      = out_sample;
  assign smp.note_letter = out_note;

`ifndef NO_ASSERTIONS
  a_kp_from_key: assert property (@(posedge clk) disable iff (rst)
    kp_valid |-> $past(key_acc && kmap.hit))
    else $error("step forward without a mapped key press");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !tick_acc |=> $stable(phase))
    else $error("phase moved without a sample tick");

  a_seed_in_sweep: assert property (@(posedge clk) disable iff (rst)
    stat.seed |-> stat.busy && !cmd_acc)
    else $error("step seed outside the reset sweep");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv_out |=> s1_valid && $stable(s1_note) && $stable(rom_dout))
    else $error("ROM stage lost a sample under stall");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_sample != {1'b1, {(SAMPLE_BITS-1){1'b0}}})
    else $error("sample outside symmetric range");
`endif

endmodule
`default_nettype wire
